FILE: rtl/gmdfs_pkg.sv
package gmdfs_pkg;

   // Field widths of the configuration, item and result ports, and of a direction code
   localparam int CELL_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 4;
   localparam int DIR_W      = 3;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_SIDE = 3'd0,
      CSR_START_ROW = 3'd1,
      CSR_START_COL = 3'd2,
      CSR_GOAL_ROW  = 3'd3,
      CSR_GOAL_COL  = 3'd4
   } csr_index_type;

   // Item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SOLVE = 1'b1;

   // Search directions in trial order; DIR_DONE means all four tried
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

   // Cell memory word: wall flag and visited flag
   localparam int CELL_DATA_W = 2;
   localparam int WALL_BIT    = 1;
   localparam int VISIT_BIT   = 0;

endpackage

FILE: rtl/grid_maze_dfs_path_finder.sv
// Cell write item: taken with no result.
// Solve item: a visited-flag sweep that keeps the walls, then a depth-first search that
// tries each direction of the top cell in turn and backs out of a cell with none left.
// Unstalled, the goal and top cells leave in consecutive cycles; each later cell waits
// on a stack read. One item at a time. Synchronous reset loads the register defaults and
// sweeps the cell memory to open, during which no item is taken.
module grid_maze_dfs_path_finder #(
   parameter int MAX_SIDE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gmdfs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [gmdfs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [gmdfs_pkg::CELL_W-1:0]      req_cell_row,
   input  logic [gmdfs_pkg::CELL_W-1:0]      req_cell_col,
   input  logic                              req_is_wall,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gmdfs_pkg::CELL_W-1:0]      rsp_path_row,
   output logic [gmdfs_pkg::CELL_W-1:0]      rsp_path_col,
   output logic                              rsp_found,
   output logic                              rsp_last
);
   import gmdfs_pkg::*;

   localparam int RB    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int AW    = 2 * RB;
   localparam int CELLS = 1 << AW;
   localparam int DW    = $clog2(CELLS + 1);
   localparam int SW    = 2 * RB + DIR_W;
   localparam int SIDE_W = CELL_W + 1;

   localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);
   localparam logic [DW-1:0]     CELLS_V    = DW'(CELLS);
   localparam logic [DW-1:0]     ONE_V      = DW'(1);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START_RD,
      S_START_CHK,
      S_TRY,
      S_CHECK,
      S_POP,
      S_GOAL,
      S_TOP,
      S_ERD,
      S_EWAIT,
      S_NF
   } state_type;

   // Configuration registers
   logic [SIDE_W-1:0] grid_side_ff;
   logic [CELL_W-1:0] start_row_ff;
   logic [CELL_W-1:0] start_col_ff;
   logic [CELL_W-1:0] goal_row_ff;
   logic [CELL_W-1:0] goal_col_ff;

   // Search state
   state_type         state_ff;
   logic              keep_ff;
   logic [DW-1:0]     cnt_ff;
   logic [DW-1:0]     depth_ff;
   logic [CELL_W-1:0] top_row_ff;
   logic [CELL_W-1:0] top_col_ff;
   logic [DIR_W-1:0]  top_dir_ff;
   logic [CELL_W-1:0] nb_row_ff;
   logic [CELL_W-1:0] nb_col_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [CELL_W-1:0] rsp_row_ff;
   logic [CELL_W-1:0] rsp_col_ff;
   logic              rsp_found_ff;
   logic              rsp_last_ff;

   // Memory ports
   logic                   cell_wr_en;
   logic [AW-1:0]          cell_wr_addr;
   logic [CELL_DATA_W-1:0] cell_wr_data;
   logic                   cell_rd_en;
   logic [AW-1:0]          cell_rd_addr;
   logic [CELL_DATA_W-1:0] cell_rd;
   logic                   stk_wr_en;
   logic [AW-1:0]          stk_wr_addr;
   logic [SW-1:0]          stk_wr_data;
   logic                   stk_rd_en;
   logic [AW-1:0]          stk_rd_addr;
   logic [SW-1:0]          stk_rd;

   // Derived values
   logic [SIDE_W-1:0] side;
   logic              start_ok;
   logic              start_is_goal;
   logic              in_range;
   logic [AW-1:0]     start_addr;
   logic [SIDE_W-1:0] row_ext;
   logic [SIDE_W-1:0] col_ext;
   logic [SIDE_W-1:0] nb_r;
   logic [SIDE_W-1:0] nb_c;
   logic              nb_ok;
   logic              nb_goal;
   logic              blocked;
   logic              out_free;
   logic [DW-1:0]     cnt_m1;
   logic [DW-1:0]     depth_m1;
   logic [DW-1:0]     depth_m2;

   // Clamp the side and check the start cell
   assign side          = (grid_side_ff > MAX_SIDE_V) ? MAX_SIDE_V : grid_side_ff;
   assign start_ok      = ({1'b0, start_row_ff} < side) && ({1'b0, start_col_ff} < side);
   assign start_is_goal = (start_row_ff == goal_row_ff) && (start_col_ff == goal_col_ff);
   assign in_range      = ({1'b0, req_cell_row} < MAX_SIDE_V) &&
                          ({1'b0, req_cell_col} < MAX_SIDE_V);
   assign start_addr    = {start_row_ff[RB-1:0], start_col_ff[RB-1:0]};
   assign blocked       = cell_rd[WALL_BIT] | cell_rd[VISIT_BIT];
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1        = cnt_ff - ONE_V;
   assign depth_m1      = depth_ff - ONE_V;
   assign depth_m2      = depth_ff - DW'(2);

   // Step from the top cell in its current direction
   always_comb begin
      row_ext = {1'b0, top_row_ff};
      col_ext = {1'b0, top_col_ff};
      nb_r    = row_ext;
      nb_c    = col_ext;
      nb_ok   = 1'b0;
      case (top_dir_ff)
         DIR_RIGHT: begin
            nb_c  = col_ext + SIDE_W'(1);
            nb_ok = nb_c < side;
         end
         DIR_DOWN: begin
            nb_r  = row_ext + SIDE_W'(1);
            nb_ok = nb_r < side;
         end
         DIR_LEFT: begin
            nb_c  = col_ext - SIDE_W'(1);
            nb_ok = top_col_ff != '0;
         end
         DIR_UP: begin
            nb_r  = row_ext - SIDE_W'(1);
            nb_ok = top_row_ff != '0;
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
      nb_goal = (nb_r[CELL_W-1:0] == goal_row_ff) && (nb_c[CELL_W-1:0] == goal_col_ff);
   end

   // Drive the memory ports from the state
   always_comb begin
      cell_wr_en   = 1'b0;
      cell_wr_addr = '0;
      cell_wr_data = '0;
      cell_rd_en   = 1'b0;
      cell_rd_addr = '0;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = depth_m1[AW-1:0];
      stk_wr_data  = {top_row_ff[RB-1:0], top_col_ff[RB-1:0], top_dir_ff};
      stk_rd_en    = 1'b0;
      stk_rd_addr  = depth_m2[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            cell_rd_en   = cnt_ff < CELLS_V;
            cell_rd_addr = cnt_ff[AW-1:0];
            if (keep_ff) begin
               // Write back the wall flag one entry behind the read
               cell_wr_en   = cnt_ff != '0;
               cell_wr_addr = cnt_m1[AW-1:0];
               cell_wr_data = {cell_rd[WALL_BIT], 1'b0};
            end else begin
               cell_wr_en   = cnt_ff < CELLS_V;
               cell_wr_addr = cnt_ff[AW-1:0];
            end
         end
         S_IDLE: begin
            cell_wr_en   = req_valid && (req_func == FUNC_WRITE) && in_range;
            cell_wr_addr = {req_cell_row[RB-1:0], req_cell_col[RB-1:0]};
            cell_wr_data = {req_is_wall, 1'b0};
         end
         S_START_RD: begin
            cell_rd_en   = 1'b1;
            cell_rd_addr = start_addr;
         end
         S_START_CHK: begin
            cell_wr_en   = !cell_rd[WALL_BIT];
            cell_wr_addr = start_addr;
            cell_wr_data = {1'b0, 1'b1};
         end
         S_TRY: begin
            cell_rd_en   = (top_dir_ff != DIR_DONE) && nb_ok;
            cell_rd_addr = {nb_r[RB-1:0], nb_c[RB-1:0]};
            stk_rd_en    = (top_dir_ff == DIR_DONE) && (depth_ff != ONE_V);
         end
         S_CHECK: begin
            cell_wr_en   = !blocked;
            cell_wr_addr = {nb_row_ff[RB-1:0], nb_col_ff[RB-1:0]};
            cell_wr_data = {1'b0, 1'b1};
            stk_wr_en    = !blocked;
         end
         S_ERD: begin
            stk_rd_en   = 1'b1;
            stk_rd_addr = depth_m1[AW-1:0];
         end
         default: begin
            cell_wr_en = 1'b0;
         end
      endcase
   end

   // Wall and visited flags, one word per cell
   gmdfs_ram #(
      .WIDTH (CELL_DATA_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd)
   );

   // Frames below the top frame: cell and next direction
   gmdfs_ram #(
      .WIDTH (SW),
      .DEPTH (CELLS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= SIDE_W'(8);
         start_row_ff <= '0;
         start_col_ff <= '0;
         goal_row_ff  <= CELL_W'(7);
         goal_col_ff  <= CELL_W'(7);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GRID_SIDE: grid_side_ff <= csr_wdata;
            CSR_START_ROW: start_row_ff <= csr_wdata[CELL_W-1:0];
            CSR_START_COL: start_col_ff <= csr_wdata[CELL_W-1:0];
            CSR_GOAL_ROW:  goal_row_ff  <= csr_wdata[CELL_W-1:0];
            CSR_GOAL_COL:  goal_col_ff  <= csr_wdata[CELL_W-1:0];
            default: begin
               grid_side_ff <= grid_side_ff;
            end
         endcase
      end
   end

   // Search sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         keep_ff      <= 1'b0;
         cnt_ff       <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken
         if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + ONE_V;
               if (cnt_ff == CELLS_V) begin
                  cnt_ff   <= '0;
                  state_ff <= keep_ff ? S_START_RD : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && (req_func == FUNC_SOLVE)) begin
                  depth_ff <= '0;
                  if (!start_ok) begin
                     state_ff <= S_NF;
                  end else if (start_is_goal) begin
                     state_ff <= S_GOAL;
                  end else begin
                     cnt_ff   <= '0;
                     keep_ff  <= 1'b1;
                     state_ff <= S_CLEAR;
                  end
               end
            end
            S_START_RD: begin
               state_ff <= S_START_CHK;
            end
            S_START_CHK: begin
               if (cell_rd[WALL_BIT]) begin
                  state_ff <= S_NF;
               end else begin
                  top_row_ff <= start_row_ff;
                  top_col_ff <= start_col_ff;
                  top_dir_ff <= DIR_RIGHT;
                  depth_ff   <= ONE_V;
                  state_ff   <= S_TRY;
               end
            end
            S_TRY: begin
               if (top_dir_ff == DIR_DONE) begin
                  // Back out of an exhausted frame
                  if (depth_ff == ONE_V) begin
                     depth_ff <= '0;
                     state_ff <= S_NF;
                  end else begin
                     state_ff <= S_POP;
                  end
               end else begin
                  top_dir_ff <= top_dir_ff + DIR_W'(1);
                  nb_row_ff  <= nb_r[CELL_W-1:0];
                  nb_col_ff  <= nb_c[CELL_W-1:0];
                  if (nb_ok) begin
                     state_ff <= nb_goal ? S_GOAL : S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               // If the neighbour is open, push the top frame and enter the neighbour
               if (!blocked) begin
                  top_row_ff <= nb_row_ff;
                  top_col_ff <= nb_col_ff;
                  top_dir_ff <= DIR_RIGHT;
                  depth_ff   <= depth_ff + ONE_V;
               end
               state_ff <= S_TRY;
            end
            S_POP: begin
               top_row_ff <= CELL_W'(stk_rd[SW-1 -: RB]);
               top_col_ff <= CELL_W'(stk_rd[DIR_W+RB-1 -: RB]);
               top_dir_ff <= stk_rd[DIR_W-1:0];
               depth_ff   <= depth_m1;
               state_ff   <= S_TRY;
            end
            S_GOAL: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= goal_row_ff;
                  rsp_col_ff   <= goal_col_ff;
                  rsp_found_ff <= 1'b1;
                  rsp_last_ff  <= depth_ff == '0;
                  state_ff     <= (depth_ff == '0) ? S_IDLE : S_TOP;
               end
            end
            S_TOP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= top_row_ff;
                  rsp_col_ff   <= top_col_ff;
                  rsp_found_ff <= 1'b1;
                  rsp_last_ff  <= depth_ff == ONE_V;
                  depth_ff     <= depth_m1;
                  state_ff     <= (depth_ff == ONE_V) ? S_IDLE : S_ERD;
               end
            end
            S_ERD: begin
               state_ff <= S_EWAIT;
            end
            S_EWAIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= CELL_W'(stk_rd[SW-1 -: RB]);
                  rsp_col_ff   <= CELL_W'(stk_rd[DIR_W+RB-1 -: RB]);
                  rsp_found_ff <= 1'b1;
                  rsp_last_ff  <= depth_ff == ONE_V;
                  depth_ff     <= depth_m1;
                  state_ff     <= (depth_ff == ONE_V) ? S_IDLE : S_ERD;
               end
            end
            S_NF: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= '0;
                  rsp_col_ff   <= '0;
                  rsp_found_ff <= 1'b0;
                  rsp_last_ff  <= 1'b1;
                  depth_ff     <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall    = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_path_row = rsp_row_ff;
   assign rsp_path_col = rsp_col_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: rtl/gmdfs_ram.sv
module gmdfs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gmdfs_checker.sv
module gmdfs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [gmdfs_pkg::CELL_W-1:0] rsp_path_row,
   input logic [gmdfs_pkg::CELL_W-1:0] rsp_path_col,
   input logic                         rsp_found,
   input logic                         rsp_last
);
   import gmdfs_pkg::*;

   // No result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_path_row) &&
         $stable(rsp_path_col) && $stable(rsp_found) && $stable(rsp_last))
      else $error("stalled result changed");

   // A not-found result stands alone, at the origin
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && (rsp_path_row == '0) && (rsp_path_col == '0))
      else $error("malformed not-found result");

   // No new item is taken while a path is still being sent
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("item taken in the middle of a path");

   // A path result that is not the last is always a found cell
   a_path_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_found)
      else $error("not-found result inside a path");

endmodule

bind grid_maze_dfs_path_finder gmdfs_checker u_gmdfs_checker (.*);
